// ===== design/b769u_pkg.sv =====
// Shared types, constants and the divide-by-769 helper for the base-769 unpacker.
`default_nettype none

package b769u_pkg;

  // Field widths.
  localparam int WordW  = 64;
  localparam int GroupW = 48;
  localparam int ChunkW = 24;
  localparam int CoefW  = 10;
  localparam int IdxW   = 9;
  localparam int PosW   = 7;

  // Digit radix and the reciprocal used for division by it.
  localparam logic [CoefW-1:0] Radix      = 10'd769;
  localparam int               RecipShift = 34;
  localparam logic [24:0]      Recip769   = 25'((64'd1 << RecipShift) / 64'(Radix));

  // 2^24 = ChunkQuo * 769 + ChunkRem, used to chain the two 24-bit chunks.
  localparam logic [14:0]      ChunkQuo = 15'((64'd1 << ChunkW) / 64'(Radix));
  localparam logic [CoefW-1:0] ChunkRem = 10'((64'd1 << ChunkW) % 64'(Radix));

  // Key layout.
  localparam logic [PosW-1:0] LastWord    = 7'd76;
  localparam logic [IdxW-1:0] MaxIndex    = 9'd511;
  localparam logic [IdxW-1:0] GroupStep   = 9'd5;
  localparam logic [IdxW-1:0] TripleStep  = 9'd10;
  localparam logic [2:0]      GroupDigits = 3'd5;
  localparam logic [2:0]      TailDigits  = 3'd2;

  // Default depth of the group queue between front and back.
  localparam int QueueDepth = 4;

  // One group of digits to be split by the back end.
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [IdxW-1:0]   base;
    logic              tail;
    logic              run_last;
  } grp_t;

  // Quotient and remainder of a division by 769.
  typedef struct packed {
    logic [15:0]      quo;
    logic [CoefW-1:0] rem;
  } div_t;

  // Divides a value below 2^25 by 769 with a reciprocal multiply and one correction.
  function automatic div_t div769(input logic [24:0] x);
    logic [49:0] prod;
    logic [15:0] qe;
    logic [25:0] re;
    div_t        res;
    prod = 50'(x) * 50'(Recip769);
    qe   = prod[49:34];
    re   = 26'(x) - 26'(qe) * 26'(Radix);
    if (re >= 26'(Radix)) begin
      res.quo = qe + 16'd1;
      res.rem = 10'(re - 26'(Radix));
    end else begin
      res.quo = qe;
      res.rem = 10'(re);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/b769u_front.sv =====
// Front end: accepts packed words, tracks the key position and forms digit groups.
`default_nettype none

module b769u_front
  import b769u_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [WordW-1:0]  packed_word_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output grp_t                   entry_o
);

  // Slot of the current word inside its triple.
  typedef enum logic [1:0] {
    SlotFirst,
    SlotSecond,
    SlotThird
  } slot_e;

  logic [PosW-1:0] pos_q, pos_d;
  slot_e           slot_q, slot_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     coll_q, coll_d;
  logic            pend_valid_q, pend_valid_d;
  grp_t            pend_q, pend_d;

  logic        accept;
  logic        last_word;
  logic [15:0] hi;
  grp_t        new_entry;

  assign hi        = packed_word_i[63:48];
  assign last_word = (pos_q == LastWord);
  assign accept    = in_valid_i && in_ready_o;

  // A word with a second group holds the input until that group is queued.
  assign in_ready_o = !pend_valid_q && !full_i;
  assign push_o     = !full_i && (pend_valid_q || in_valid_i);

  // The word's own low group comes first.
  always_comb begin
    new_entry.group    = packed_word_i[GroupW-1:0];
    new_entry.base     = idx_q;
    new_entry.tail     = 1'b0;
    new_entry.run_last = !(last_word || slot_q == SlotThird);
  end

  assign entry_o = pend_valid_q ? pend_q : new_entry;

  // Position, collector and second-group bookkeeping.
  always_comb begin
    pos_d        = pos_q;
    slot_d       = slot_q;
    idx_d        = idx_q;
    coll_d       = coll_q;
    pend_valid_d = pend_valid_q && full_i;
    pend_d       = pend_q;
    if (accept) begin
      if (last_word) begin
        pend_d.group    = {28'd0, packed_word_i[51:48], coll_q[15:0]};
        pend_d.base     = idx_q + GroupStep;
        pend_d.tail     = 1'b1;
        pend_d.run_last = 1'b1;
        pend_valid_d    = 1'b1;
        pos_d           = '0;
        slot_d          = SlotFirst;
        idx_d           = '0;
      end else begin
        pos_d = pos_q + 7'd1;
        case (slot_q)
          SlotFirst: begin
            coll_d = {16'd0, hi};
            idx_d  = idx_q + GroupStep;
            slot_d = SlotSecond;
          end
          SlotSecond: begin
            coll_d[31:16] = hi;
            idx_d         = idx_q + GroupStep;
            slot_d        = SlotThird;
          end
          SlotThird: begin
            pend_d.group    = {hi, coll_q};
            pend_d.base     = idx_q + GroupStep;
            pend_d.tail     = 1'b0;
            pend_d.run_last = 1'b1;
            pend_valid_d    = 1'b1;
            idx_d           = idx_q + TripleStep;
            slot_d          = SlotFirst;
          end
          default: begin
            slot_d = SlotFirst;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      slot_q       <= SlotFirst;
      idx_q        <= '0;
      coll_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      slot_q       <= slot_d;
      idx_q        <= idx_d;
      coll_q       <= coll_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

// ===== design/b769u_queue.sv =====
// Short queue of digit groups between the front end and the digit back end.
`default_nettype none

module b769u_queue
  import b769u_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire grp_t entry_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output grp_t      entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Storage for queued groups.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b769u_digit.sv =====
// Back end: splits queued groups into base-769 digits, one digit per cycle while the output is not stalled.
`default_nettype none

module b769u_digit
  import b769u_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire grp_t             q_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CoefW-1:0]      coefficient_o,
  output logic [IdxW-1:0]       coeff_index_o,
  output logic                  run_last_o,
  output logic                  poly_last_o
);

  // Stage A: divides the high chunk of the running value.
  logic              s1_valid_q;
  logic [ChunkW-1:0] s1_hi_q;
  logic [ChunkW-1:0] s1_lo_q;
  logic              s1_first_q;
  logic [2:0]        s1_cnt_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s1_runl_q;

  // Stage B: folds the high remainder into the low chunk.
  logic              s2_valid_q;
  logic [CoefW-1:0]  s2_ra_q;
  logic [ChunkW-1:0] s2_lo_q;
  logic              s2_first_q;
  logic [IdxW-1:0]   s2_idx_q;
  logic              s2_runl_q;

  // Low chunk of the quotient left by the previous digit.
  logic [ChunkW-1:0] qlo_q, qlo_d;

  logic [CoefW-1:0]  coef_q;
  logic [IdxW-1:0]   oidx_q;
  logic              orunl_q;
  logic              opoly_q;

  logic              adv;
  logic              s1_more;
  logic              s1_last;
  div_t              da, db;
  logic [ChunkW-1:0] lo_sel;
  logic [24:0]       x;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv     = !out_valid_o || out_ready_i;
  assign s1_last = (s1_cnt_q == 3'd1);
  assign s1_more = s1_valid_q && !s1_last;
  assign pop_o   = adv && !s1_more && q_valid_i;

  // Stage A arithmetic.
  assign da = div769({1'b0, s1_hi_q});

  // Stage B arithmetic: (ra * 2^24 + lo) / 769 split into two small terms.
  assign lo_sel = s2_first_q ? s2_lo_q : qlo_q;
  assign x      = 25'(s2_ra_q) * 25'(ChunkRem) + 25'(lo_sel);
  assign db     = div769(x);
  assign qlo_d  = 24'(s2_ra_q) * 24'(ChunkQuo) + 24'(db.quo);

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= s1_more || q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_o <= s2_valid_q;
    end
  end

  // Stage payloads and the output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s1_more) begin
        s1_hi_q    <= 24'(da.quo);
        s1_first_q <= 1'b0;
        s1_cnt_q   <= s1_cnt_q - 3'd1;
        s1_idx_q   <= s1_idx_q + 9'd1;
      end else begin
        s1_hi_q    <= q_entry_i.group[GroupW-1:ChunkW];
        s1_lo_q    <= q_entry_i.group[ChunkW-1:0];
        s1_first_q <= 1'b1;
        s1_cnt_q   <= q_entry_i.tail ? TailDigits : GroupDigits;
        s1_idx_q   <= q_entry_i.base;
        s1_runl_q  <= q_entry_i.run_last;
      end
      s2_ra_q    <= da.rem;
      s2_lo_q    <= s1_lo_q;
      s2_first_q <= s1_first_q;
      s2_idx_q   <= s1_idx_q;
      s2_runl_q  <= s1_runl_q && s1_last;
      if (s2_valid_q) begin
        qlo_q <= qlo_d;
      end
      coef_q  <= db.rem;
      oidx_q  <= s2_idx_q;
      orunl_q <= s2_runl_q;
      opoly_q <= (s2_idx_q == MaxIndex);
    end
  end

  assign coefficient_o = coef_q;
  assign coeff_index_o = oidx_q;
  assign run_last_o    = orunl_q;
  assign poly_last_o   = opoly_q;

endmodule

`default_nettype wire

// ===== design/base769_coefficient_unpacker.sv =====
// Coefficients pass the group queue, stage A, stage B and the output register.
// Throughput: one coefficient per cycle from the digit back end while the output is not
// stalled; words give 5, 10 (third of a triple) or 7 (last) digits, about 6.6 on average.
// A two-stage chunked divide-by-769 pipeline sets that one-coefficient-per-cycle figure.
// Reset is asynchronous and active low; it returns the block to word 0 with empty queue.
`default_nettype none

module base769_coefficient_unpacker
  import b769u_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WordW-1:0] packed_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CoefW-1:0]      coefficient_o,
  output logic [IdxW-1:0]       coeff_index_o,
  output logic                  run_last_o,
  output logic                  poly_last_o
);

  logic q_push, q_full, q_valid, q_pop;
  grp_t push_entry, head_entry;

  // Word intake and group formation.
  b769u_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .packed_word_i (packed_word_i),
    .full_i        (q_full),
    .push_o        (q_push),
    .entry_o       (push_entry)
  );

  // Group queue.
  b769u_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (head_entry)
  );

  // Digit extraction.
  b769u_digit u_digit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .coeff_index_o (coeff_index_o),
    .run_last_o    (run_last_o),
    .poly_last_o   (poly_last_o)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("group pushed into a full queue");

  // Every emitted digit is reduced below the radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> coefficient_o < Radix)
    else $error("coefficient not reduced below 769");

  // The final coefficient of the key ends the run of the last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && poly_last_o |-> run_last_o && coeff_index_o == MaxIndex)
    else $error("end of polynomial not aligned with end of word");

endmodule

`default_nettype wire

// ===== verif/tb_base769_coefficient_unpacker.sv =====
// Self-checking testbench for the base-769 coefficient unpacker with a scoreboard class.
module tb_base769_coefficient_unpacker;
  import b769u_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomWords   = 300;
  localparam int DrainCycles   = 20;
  localparam int SegmentLen    = 40;
  localparam int WordsPerKey   = int'(LastWord) + 1;

  // Smallest 48-bit group that no longer fits in five base-769 digits.
  localparam logic [WordW-1:0] GroupCeil =
    64'(Radix) * 64'(Radix) * 64'(Radix) * 64'(Radix) * 64'(Radix);

  // Index bases of the last two low groups.
  localparam int unsigned PairBase  = 500;
  localparam int unsigned FinalBase = 505;

  // Tracks the key layout and holds the coefficients still to come.
  class unpack_scoreboard;
    typedef struct {
      logic [CoefW-1:0] value;
      logic [IdxW-1:0]  index;
      logic             run_last;
      logic             poly_last;
    } coef_t;

    coef_t           expected_coefs[$];
    logic [PosW-1:0] word_pos;
    logic [31:0]     hi_collect;
    int              errors;

    function new();
      word_pos   = '0;
      hi_collect = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_coefs.size();
    endfunction

    // Queues one digit at the given polynomial index.
    function void push_digit(logic [WordW-1:0] value, int unsigned idx);
      coef_t c;
      c.value     = value[CoefW-1:0];
      c.index     = IdxW'(idx);
      c.run_last  = 1'b0;
      c.poly_last = (c.index == MaxIndex);
      expected_coefs.push_back(c);
    endfunction

    // Splits a 48-bit group into five digits; whatever is left above them is dropped.
    function void push_group(logic [GroupW-1:0] grp, int unsigned base);
      logic [GroupW-1:0] rest;
      rest = grp;
      for (int j = 0; j < 5; j++) begin
        push_digit(WordW'(rest % GroupW'(Radix)), base + j);
        rest = rest / GroupW'(Radix);
      end
    endfunction

    // Works out every coefficient that one accepted word produces.
    function void predict_word(logic [WordW-1:0] w);
      logic [15:0]  hi;
      logic [19:0]  tail;
      int unsigned  p;
      int unsigned  t;
      int unsigned  m;
      coef_t        last_coef;
      hi = w[WordW-1:GroupW];
      p  = word_pos;
      if (p < LastWord - 1) begin
        t = p / 3;
        m = p % 3;
        push_group(w[GroupW-1:0], 20 * t + 5 * m);
        // The top fields of a triple build a fourth group behind the third word.
        if (m == 0) begin
          hi_collect = {16'h0000, hi};
        end else if (m == 1) begin
          hi_collect = hi_collect | {hi, 16'h0000};
        end else begin
          push_group({hi, hi_collect}, 20 * t + 15);
        end
        word_pos = word_pos + 1'b1;
      end else if (p == LastWord - 1) begin
        push_group(w[GroupW-1:0], PairBase);
        hi_collect = {16'h0000, hi};
        word_pos   = LastWord;
      end else begin
        // The tail takes four bits of the last word over the top field of the one before.
        tail = {w[51:48], hi_collect[15:0]};
        push_group(w[GroupW-1:0], FinalBase);
        push_digit(WordW'(tail % 20'(Radix)), MaxIndex - 1'b1);
        push_digit(WordW'((tail / 20'(Radix)) % 20'(Radix)), MaxIndex);
        word_pos = '0;
      end
      last_coef = expected_coefs.pop_back();
      last_coef.run_last = 1'b1;
      expected_coefs.push_back(last_coef);
    endfunction

    // Compares one accepted coefficient with the oldest expectation.
    function void check_coef(logic [CoefW-1:0] value, logic [IdxW-1:0] idx,
                             logic run_last, logic poly_last);
      coef_t e;
      if (expected_coefs.size() == 0) begin
        $error("coefficient with no expectation: coeff_index %0d coefficient %0d",
               idx, value);
        errors++;
        return;
      end
      e = expected_coefs.pop_front();
      if (value !== e.value) begin
        $error("coefficient: expected %0d, actual %0d", e.value, value);
        errors++;
      end
      if (idx !== e.index) begin
        $error("coeff_index: expected %0d, actual %0d", e.index, idx);
        errors++;
      end
      if (run_last !== e.run_last) begin
        $error("run_last: expected %0b, actual %0b", e.run_last, run_last);
        errors++;
      end
      if (poly_last !== e.poly_last) begin
        $error("poly_last: expected %0b, actual %0b", e.poly_last, poly_last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             word_valid     = 1'b0;
  logic             word_ready;
  logic [WordW-1:0] word_data      = '0;
  logic             coef_valid;
  logic             coef_ready     = 1'b0;
  logic [CoefW-1:0] coef_value;
  logic [IdxW-1:0]  coef_index;
  logic             coef_run_last;
  logic             coef_poly_last;

  unpack_scoreboard sb = new();
  bit               steady      = 1'b0;
  int               words_sent  = 0;
  int               rx_stall    = 0;
  int               idle_cycles = 0;

  // Extremes of the digit groups and the top fields.
  logic [WordW-1:0] directed_words [15] = '{
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF,
    {16'hFFFF, 48'(GroupCeil - 1)},
    {16'h0000, 48'(GroupCeil)},
    {16'hFFFF, 48'h0000_0000_0000},
    {16'hFFFF, 48'hFFFF_FFFF_FFFF},
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_0000_0300,
    64'h0123_4567_89AB_CDEF,
    64'hFEDC_BA98_7654_3210,
    {16'h8000, 48'(GroupCeil - 1)}
  };

  base769_coefficient_unpacker DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (word_valid),
    .in_ready_o   (word_ready),
    .packed_word_i(word_data),
    .out_valid_o  (coef_valid),
    .out_ready_i  (coef_ready),
    .coefficient_o(coef_value),
    .coeff_index_o(coef_index),
    .run_last_o   (coef_run_last),
    .poly_last_o  (coef_poly_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Random word, biased toward the overflow cases; the first key ends on all ones.
  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    w = {$urandom, $urandom};
    if (words_sent >= WordsPerKey - 2 && words_sent < WordsPerKey) begin
      return '1;
    end
    case ($urandom_range(0, 9))
      0: w = '1;
      1: w = '0;
      2: w[GroupW-1:0] = 48'(GroupCeil - 64'($urandom_range(0, 1)));
      3: w[GroupW-1:0] = '1;
      4: w[WordW-1:GroupW] = '1;
      default: ;
    endcase
    return w;
  endfunction

  // Presents one word and waits for its transaction.
  task automatic send_word(input logic [WordW-1:0] w);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_valid <= 1'b1;
    word_data  <= w;
    do @(posedge clk_i); while (!word_ready);
    sb.predict_word(w);
    words_sent++;
  endtask

  // Holds the sender off until every expected coefficient has come out.
  task automatic wait_for_drain();
    word_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Result side: check every transaction and stall at random.
  always @(posedge clk_i) begin
    if (coef_valid && coef_ready) begin
      sb.check_coef(coef_value, coef_index, coef_run_last, coef_poly_last);
    end
    if (!rst_ni || rx_stall > 0) begin
      coef_ready <= 1'b0;
      if (rx_stall > 0) rx_stall--;
    end else begin
      coef_ready <= 1'b1;
      rx_stall = steady ? 0 : pick_gap();
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (word_valid && word_ready) || (coef_valid && coef_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("base769_coefficient_unpacker verification failed");
      $finish;
    end
  end

  // Stimulus: directed words, a full drain, then random words in segments.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end
    wait_for_drain();

    for (int i = 0; i < RandomWords; i++) begin
      if (i % SegmentLen == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == RandomWords / 2) wait_for_drain();
      send_word(random_word());
    end
    word_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("base769_coefficient_unpacker verification clean");
    end else begin
      $display("base769_coefficient_unpacker verification failed");
    end
    $finish;
  end

endmodule
